### rtl/memory_fill_write_generator_top_macros.svh
// assertion helpers for the top rtl file
`ifndef MEMORY_FILL_WRITE_GENERATOR_TOP_MACROS_SVH
`define MEMORY_FILL_WRITE_GENERATOR_TOP_MACROS_SVH

// checked while out of reset
`define MFWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define MFWG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/mfwg_pkg.sv
`timescale 1ns / 1ps

package mfwg_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned THRESHOLD = 8;
  localparam int unsigned PC_W      = 3;

  // step addresses of the control program
  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_MOD   = 3'd1;
  localparam logic [PC_W-1:0] STEP_CHECK = 3'd2;
  localparam logic [PC_W-1:0] STEP_HEAD  = 3'd3;
  localparam logic [PC_W-1:0] STEP_WORDS = 3'd4;
  localparam logic [PC_W-1:0] STEP_TAIL  = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MOD,
    OP_BYTE,
    OP_WORD
  } op_e;

  typedef enum logic [2:0] {
    COND_IN_VALID,
    COND_ALWAYS,
    COND_SHORT,
    COND_HEAD,
    COND_WORD,
    COND_BYTE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  tgt_true;
    logic [PC_W-1:0]  tgt_false;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic short_req;
    logic head_more;
    logic word_more;
    logic byte_more;
    logic out_free;
  } status_t;

  typedef struct packed {
    op_e  op;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_address;
    logic [7:0]        fill_byte;
    logic [CNT_W-1:0]  byte_count;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              word_write;
    logic              last_write;
  } out_t;

  // control program
  function automatic uword_t rom_word(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_IDLE:  w = '{op: OP_ACCEPT, cond: COND_IN_VALID,
                        tgt_true: STEP_MOD,   tgt_false: STEP_IDLE};
      STEP_MOD:   w = '{op: OP_MOD,    cond: COND_ALWAYS,
                        tgt_true: STEP_CHECK, tgt_false: STEP_CHECK};
      STEP_CHECK: w = '{op: OP_NONE,   cond: COND_SHORT,
                        tgt_true: STEP_TAIL,  tgt_false: STEP_HEAD};
      STEP_HEAD:  w = '{op: OP_BYTE,   cond: COND_HEAD,
                        tgt_true: STEP_HEAD,  tgt_false: STEP_WORDS};
      STEP_WORDS: w = '{op: OP_WORD,   cond: COND_WORD,
                        tgt_true: STEP_WORDS, tgt_false: STEP_TAIL};
      STEP_TAIL:  w = '{op: OP_BYTE,   cond: COND_BYTE,
                        tgt_true: STEP_TAIL,  tgt_false: STEP_IDLE};
      default:    w = '{op: OP_NONE,   cond: COND_IN_VALID,
                        tgt_true: STEP_IDLE,  tgt_false: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/mfwg_seq.sv
`timescale 1ns / 1ps

module mfwg_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfwg_pkg::status_t status_i,
  output mfwg_pkg::ctrl_t   ctrl_o
);

  logic [mfwg_pkg::PC_W-1:0] pc_q, pc_d;
  mfwg_pkg::uword_t          uw;
  logic                      cond_true;
  logic                      can_go;

  assign uw = mfwg_pkg::rom_word(pc_q);

  always_comb begin
    case (uw.cond)
      mfwg_pkg::COND_IN_VALID: cond_true = status_i.in_valid;
      mfwg_pkg::COND_ALWAYS:   cond_true = 1'b1;
      mfwg_pkg::COND_SHORT:    cond_true = status_i.short_req;
      mfwg_pkg::COND_HEAD:     cond_true = status_i.head_more;
      mfwg_pkg::COND_WORD:     cond_true = status_i.word_more;
      mfwg_pkg::COND_BYTE:     cond_true = status_i.byte_more;
      default:                 cond_true = 1'b0;
    endcase
  end

  // write steps wait for room in the output register
  always_comb begin
    case (uw.op)
      mfwg_pkg::OP_BYTE, mfwg_pkg::OP_WORD: can_go = status_i.out_free;
      default:                              can_go = 1'b1;
    endcase
  end

  always_comb begin
    ctrl_o.op   = uw.op;
    ctrl_o.exec = cond_true && can_go;
    if (!cond_true) begin
      pc_d = uw.tgt_false;
    end else if (can_go) begin
      pc_d = uw.tgt_true;
    end else begin
      pc_d = pc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mfwg_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/memory_fill_write_generator_top.sv
`timescale 1ns / 1ps
// Fill request in, a run of write commands out, the final one flagged by last_write.
// A request goes through the program steps in order: take it, find the residue of the
// start address modulo WORD_BYTES (a reciprocal multiply), pick the path, then one
// write a cycle, while the output register has room, for leading bytes, words and
// trailing bytes. A zero count gives no writes.
// The next request can be taken while the last write still waits in the output register.

`include "memory_fill_write_generator_top_macros.svh"

module memory_fill_write_generator_top #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mfwg_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mfwg_pkg::out_t out_data_o
);

  localparam int unsigned RES_W = $clog2(WORD_BYTES);
  localparam int unsigned AW    = mfwg_pkg::ADDR_W;
  localparam int unsigned RSH   = 3;
  // quotient by WORD_BYTES is the product shifted right by AW + RSH
  localparam logic [AW:0]                  RECIP  = (AW + 1)'(
      ((64'd1 << (AW + RSH)) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES));
  localparam logic [RES_W-1:0]             W_RES  = RES_W'(WORD_BYTES);
  localparam logic [RES_W-1:0]             RES_MAX = RES_W'(WORD_BYTES - 1);
  localparam logic [mfwg_pkg::CNT_W-1:0]   W_CNT  = mfwg_pkg::CNT_W'(WORD_BYTES);
  localparam logic [mfwg_pkg::ADDR_W-1:0]  W_ADDR = mfwg_pkg::ADDR_W'(WORD_BYTES);
  localparam logic [mfwg_pkg::CNT_W-1:0]   THRESH = mfwg_pkg::CNT_W'(mfwg_pkg::THRESHOLD);

  mfwg_pkg::status_t status;
  mfwg_pkg::ctrl_t   ctrl;

  logic [AW-1:0]                  addr_q, addr_d;
  logic [7:0]                     fill_q, fill_d;
  logic [mfwg_pkg::CNT_W-1:0]     remain_q, remain_d;
  logic [RES_W-1:0]               res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  mfwg_pkg::out_t                 out_q, out_d;
  logic [mfwg_pkg::DATA_W-1:0]    pattern;
  logic                           emit;
  logic [2*AW:0]                  recip_prod;
  logic [RES_W-1:0]               quot_lo;

  always_comb begin
    for (int i = 0; i < mfwg_pkg::DATA_W / 8; i++) begin
      pattern[8*i +: 8] = (i < WORD_BYTES) ? fill_q : 8'h00;
    end
  end

  // only the low quotient bits matter for the residue
  assign recip_prod = {{(AW + 1){1'b0}}, addr_q} * {{AW{1'b0}}, RECIP};
  assign quot_lo    = recip_prod[AW + RSH +: RES_W];

  mfwg_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  always_comb begin
    status.in_valid  = in_valid_i;
    status.short_req = remain_q < THRESH;
    status.head_more = (res_q != '0) && (remain_q != '0);
    status.word_more = remain_q >= W_CNT;
    status.byte_more = remain_q != '0;
    status.out_free  = !out_valid_q || out_ready_i;
  end

  assign in_ready_o = ctrl.op == mfwg_pkg::OP_ACCEPT;
  assign emit = ctrl.exec && (ctrl.op == mfwg_pkg::OP_BYTE || ctrl.op == mfwg_pkg::OP_WORD);

  always_comb begin
    addr_d      = addr_q;
    fill_d      = fill_q;
    remain_d    = remain_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl.exec) begin
      case (ctrl.op)
        mfwg_pkg::OP_ACCEPT: begin
          addr_d   = in_data_i.start_address;
          fill_d   = in_data_i.fill_byte;
          remain_d = in_data_i.byte_count;
          res_d    = '0;
        end
        mfwg_pkg::OP_MOD: begin
          res_d = addr_q[RES_W-1:0] - quot_lo * W_RES;
        end
        mfwg_pkg::OP_BYTE: begin
          out_valid_d         = 1'b1;
          out_d.write_address = addr_q;
          out_d.write_data    = pattern;
          out_d.word_write    = 1'b0;
          out_d.last_write    = remain_q == mfwg_pkg::CNT_W'(1);
          addr_d              = addr_q + 1'b1;
          remain_d            = remain_q - 1'b1;
          // the address wraps to zero, which is aligned
          res_d               = (res_q == RES_MAX || addr_q == '1) ? '0 : res_q + 1'b1;
        end
        mfwg_pkg::OP_WORD: begin
          out_valid_d         = 1'b1;
          out_d.write_address = addr_q;
          out_d.write_data    = pattern;
          out_d.word_write    = 1'b1;
          out_d.last_write    = remain_q == W_CNT;
          addr_d              = addr_q + W_ADDR;
          remain_d            = remain_q - W_CNT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    fill_q   <= fill_d;
    remain_q <= remain_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MFWG_ASSERT(a_word_aligned, emit && ctrl.op == mfwg_pkg::OP_WORD |-> res_q == '0, "word write on unaligned address")
  `MFWG_ASSERT(a_no_empty_write, emit |-> remain_q != '0, "write issued with nothing left")
  `MFWG_ASSERT(a_last_drains, emit && out_d.last_write |=> remain_q == '0, "last write left bytes behind")
  `MFWG_ASSERT(a_take_count, in_valid_i && in_ready_o |=> remain_q == $past(in_data_i.byte_count), "count not captured")
  `MFWG_ASSERT(a_no_overwrite, out_valid_q && !out_ready_i |-> !emit, "pending write overwritten")

endmodule

### test/memory_fill_write_generator_check.sv
`timescale 1ns / 1ps

module memory_fill_write_generator_check #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  mfwg_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  mfwg_pkg::out_t out_data_i,
  output int             errors_o,
  output int             pending_o,
  output int             writes_o,
  output int             words_o
);

  mfwg_pkg::out_t pending_writes[$];

  // expand one fill request into its write commands, in address order
  function automatic void plan_fill(mfwg_pkg::in_t req);
    mfwg_pkg::out_t              run[80];
    logic [mfwg_pkg::ADDR_W-1:0] addr;
    logic [mfwg_pkg::DATA_W-1:0] pattern;
    int unsigned                 remain;
    int                          n;
    addr    = req.start_address;
    remain  = 32'(req.byte_count);
    pattern = '0;
    n       = 0;
    for (int i = 0; i < WORD_BYTES && i < 8; i++) begin
      pattern[8*i +: 8] = req.fill_byte;
    end
    if (remain >= mfwg_pkg::THRESHOLD) begin
      // leading bytes up to word alignment
      while ((addr % WORD_BYTES) != 0 && remain > 0) begin
        run[n] = '{write_address: addr, write_data: pattern, word_write: 1'b0,
                   last_write: 1'b0};
        n++;
        addr   = addr + 1;
        remain = remain - 1;
      end
      while (remain >= WORD_BYTES) begin
        run[n] = '{write_address: addr, write_data: pattern, word_write: 1'b1,
                   last_write: 1'b0};
        n++;
        addr   = addr + WORD_BYTES;
        remain = remain - WORD_BYTES;
      end
    end
    while (remain > 0) begin
      run[n] = '{write_address: addr, write_data: pattern, word_write: 1'b0,
                 last_write: 1'b0};
      n++;
      addr   = addr + 1;
      remain = remain - 1;
    end
    if (n > 0) begin
      run[n-1].last_write = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      pending_writes.push_back(run[k]);
    end
  endfunction

  always @(posedge clk_i) begin
    mfwg_pkg::out_t want;
    int             errs;
    errs = errors_o;
    if (rst_ni) begin
      // an output transfer never stems from a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (pending_writes.size() == 0) begin
          $error("write command %h with no fill request pending", out_data_i);
          errs++;
        end else begin
          want = pending_writes.pop_front();
          writes_o <= writes_o + 1;
          if (out_data_i.word_write) begin
            words_o <= words_o + 1;
          end
          if (out_data_i.write_address !== want.write_address) begin
            $error("write_address: expected %h, got %h", want.write_address,
                   out_data_i.write_address);
            errs++;
          end
          if (out_data_i.write_data !== want.write_data) begin
            $error("write_data: expected %h, got %h", want.write_data,
                   out_data_i.write_data);
            errs++;
          end
          if (out_data_i.word_write !== want.word_write) begin
            $error("word_write: expected %b, got %b", want.word_write,
                   out_data_i.word_write);
            errs++;
          end
          if (out_data_i.last_write !== want.last_write) begin
            $error("last_write: expected %b, got %b", want.last_write,
                   out_data_i.last_write);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        plan_fill(in_data_i);
      end
      pending_o <= pending_writes.size();
      errors_o  <= errs;
    end
  end

endmodule

### test/memory_fill_write_generator_top_test.sv
`timescale 1ns / 1ps

module memory_fill_write_generator_top_test;

  localparam int unsigned WORD_BYTES   = 8;
  localparam int unsigned ADDR_W       = mfwg_pkg::ADDR_W;
  localparam int unsigned CNT_W        = mfwg_pkg::CNT_W;
  localparam int          RANDOM_FILLS = 450;
  localparam int          CYCLE_LIMIT  = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic           in_valid  = 1'b0;
  logic           in_ready;
  mfwg_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  mfwg_pkg::out_t out_data;

  logic steady = 1'b0;

  int errors;
  int pending;
  int writes;
  int words;
  int cycle_count = 0;
  int sent        = 0;
  int zero_fills  = 0;
  int wrap_fills  = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  memory_fill_write_generator_top #(
    .WORD_BYTES (WORD_BYTES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  memory_fill_write_generator_check #(
    .WORD_BYTES (WORD_BYTES)
  ) i_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .writes_o    (writes),
    .words_o     (words)
  );

  // write command receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic mfwg_pkg::in_t fill_req(logic [ADDR_W-1:0] addr, logic [7:0] value,
                                             logic [CNT_W-1:0] count);
    mfwg_pkg::in_t req;
    req.start_address = addr;
    req.fill_byte     = value;
    req.byte_count    = count;
    return req;
  endfunction

  task automatic send_fill(input mfwg_pkg::in_t req);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    if (req.byte_count == 0) begin
      zero_fills++;
    end
    if ({1'b0, req.start_address} + req.byte_count > 33'h1_0000_0000) begin
      wrap_fills++;
    end
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    mfwg_pkg::in_t      directed[$];
    mfwg_pkg::in_t      req;
    int unsigned        pick;
    logic [CNT_W-1:0]   count;
    logic [ADDR_W-1:0]  addr;
    directed.push_back(fill_req(32'h0000_0000, 8'h00, 8'd0));
    directed.push_back(fill_req(32'hFFFF_FFFF, 8'hFF, 8'd0));
    directed.push_back(fill_req(32'h0000_0000, 8'hA5, 8'd1));
    directed.push_back(fill_req(32'hFFFF_FFFF, 8'h5A, 8'd7));
    directed.push_back(fill_req(32'h0000_0003, 8'h3C, 8'd7));
    directed.push_back(fill_req(32'h0000_0000, 8'hFF, 8'd8));
    directed.push_back(fill_req(32'h0000_0001, 8'h01, 8'd8));
    directed.push_back(fill_req(32'h0000_0007, 8'h80, 8'd8));
    directed.push_back(fill_req(32'h0000_0008, 8'h7F, 8'd16));
    directed.push_back(fill_req(32'h0000_0005, 8'hC3, 8'd255));
    directed.push_back(fill_req(32'hFFFF_FFF9, 8'h11, 8'd255));
    directed.push_back(fill_req(32'hFFFF_FFF8, 8'h22, 8'd255));
    directed.push_back(fill_req(32'h0000_0000, 8'h00, 8'd255));
    directed.push_back(fill_req(32'hFFFF_FFFF, 8'hFF, 8'd255));
    directed.push_back(fill_req(32'h1234_5676, 8'h96, 8'd9));
    directed.push_back(fill_req(32'hAAAA_AAAA, 8'h55, 8'd17));
    directed.push_back(fill_req(32'h5555_5555, 8'hAA, 8'd30));
    directed.push_back(fill_req(32'hFFFF_FFF0, 8'hE7, 8'd16));
    directed.push_back(fill_req(32'h8000_0004, 8'h69, 8'd15));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_fill(directed[i]);
    end
    drain_writes();

    for (int i = 0; i < RANDOM_FILLS; i++) begin
      steady <= (i >= 200 && i < 300);
      if (i == 120) begin
        drain_writes();
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        count = CNT_W'($urandom_range(7));
      end else if (pick < 52) begin
        count = CNT_W'($urandom_range(24, 8));
      end else if (pick < 82) begin
        count = CNT_W'($urandom_range(80, 25));
      end else begin
        count = CNT_W'($urandom_range(255, 81));
      end
      if ($urandom_range(9) == 0) begin
        addr = 32'hFFFF_FF00 + $urandom_range(255);
      end else begin
        addr = $urandom;
      end
      req = fill_req(addr, 8'($urandom_range(255)), count);
      send_fill(req);
    end
    drain_writes();
    repeat (40) @(posedge clk_i);

    $display("covered %0d fill requests: %0d with zero count, %0d across the address wrap",
             sent, zero_fills, wrap_fills);
    $display("checked %0d write commands, %0d of them full words", writes, words);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
